[hw/rtl/lckm_pkg.sv]
// shared types, constants and keyword table for the line command keyword matcher
// no dependencies; used by every module of the block
package lckm_pkg;

	localparam int MAX_LINE = 64;
	localparam int CNT_W = $clog2(MAX_LINE);

	localparam int KW_COUNT = 5;
	localparam int KW_SLOTS = 7;
	localparam int KW_IDX_W = $clog2(KW_SLOTS);
	localparam int LEN_W = $clog2(KW_SLOTS + 2);
	// compared length saturates one past the longest keyword
	localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(KW_SLOTS + 1);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_A_LOW = 8'h61;
	localparam logic [7:0] CH_Z_LOW = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef enum logic [2:0] {
		CMD_ON      = 3'd0,
		CMD_OFF     = 3'd1,
		CMD_BLINK   = 3'd2,
		CMD_NOBLINK = 3'd3,
		CMD_STATUS  = 3'd4,
		CMD_UNKNOWN = 3'd5
	} cmd_code_t;

	typedef enum logic [1:0] {
		KIND_CHAR,
		KIND_ZERO,
		KIND_TERM
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  ch;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
		'{"O", "N", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"O", "F", "F", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"B", "L", "I", "N", "K", CH_NUL, CH_NUL},
		'{"N", "O", "B", "L", "I", "N", "K"},
		'{"S", "T", "A", "T", "U", "S", CH_NUL}
	};

	localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
		LEN_W'(2), LEN_W'(3), LEN_W'(5), LEN_W'(7), LEN_W'(6)
	};

endpackage

[hw/rtl/lckm_front.sv]
// front stage: takes received bytes, folds case and classifies them
// depends on lckm_pkg; feeds lckm_queue
module lckm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  lckm_pkg::q_status_t q_status,
	output logic              push,
	output lckm_pkg::item_t   push_item
);

	logic            valid_s1;
	lckm_pkg::item_t item_s1;
	lckm_pkg::item_t cls;

	always_comb begin
		cls.ch = in_byte;
		if (in_byte == lckm_pkg::CH_LF || in_byte == lckm_pkg::CH_CR) begin
			cls.kind = lckm_pkg::KIND_TERM;
		end else if (in_byte == lckm_pkg::CH_NUL) begin
			cls.kind = lckm_pkg::KIND_ZERO;
		end else begin
			cls.kind = lckm_pkg::KIND_CHAR;
			if (in_byte >= lckm_pkg::CH_A_LOW && in_byte <= lckm_pkg::CH_Z_LOW) begin
				cls.ch = in_byte - lckm_pkg::CASE_OFFSET;
			end
		end
	end

	assign push = valid_s1 && !q_status.full;
	assign in_ready = !valid_s1 || !q_status.full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls;
		end
	end

	property p_no_accept_blocked;
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && q_status.full) |-> !in_ready;
	endproperty
	a_no_accept_blocked: assert property (p_no_accept_blocked)
		else $error("front accepts while its stage is blocked");

	property p_stage_holds;
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && q_status.full) |=> (valid_s1 && $stable(item_s1));
	endproperty
	a_stage_holds: assert property (p_stage_holds)
		else $error("blocked request changed in the front stage");

endmodule

[hw/rtl/lckm_queue.sv]
// short queue of classified bytes between the front and back stages
// depends on lckm_pkg
module lckm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lckm_pkg::item_t     push_item,
	input  logic                pop,
	output lckm_pkg::item_t     head_item,
	output lckm_pkg::q_status_t status
);

	lckm_pkg::item_t                mem_q [lckm_pkg::QDEPTH];
	logic [lckm_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [lckm_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [lckm_pkg::QPTR_W:0]      count_q;

	assign status.full = (count_q == (lckm_pkg::QPTR_W + 1)'(lckm_pkg::QDEPTH));
	assign status.empty = (count_q == '0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lckm_pkg::QPTR_W'(lckm_pkg::QDEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lckm_pkg::QPTR_W'(lckm_pkg::QDEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n)
		count_q <= (lckm_pkg::QPTR_W + 1)'(lckm_pkg::QDEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("queue over-filled");

	property p_no_pop_empty;
		@(posedge clk) disable iff (!arst_n) pop |-> !status.empty;
	endproperty
	a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

	property p_no_push_full;
		@(posedge clk) disable iff (!arst_n) push |-> !status.full;
	endproperty
	a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");

endmodule

[hw/rtl/lckm_back.sv]
// back stage: keeps per-keyword match flags and issues a command code per line
// depends on lckm_pkg; drains lckm_queue and drives the output register
module lckm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lckm_pkg::q_status_t q_status,
	input  lckm_pkg::item_t     head_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output lckm_pkg::cmd_code_t out_code
);

	logic [lckm_pkg::CNT_W-1:0]    stored_cnt_q;
	logic [lckm_pkg::KW_COUNT-1:0] alive_q;
	logic                          text_ended_q;
	logic [lckm_pkg::LEN_W-1:0]    cmp_len_q;
	logic                          out_valid_q;
	lckm_pkg::cmd_code_t           out_code_q;

	logic [lckm_pkg::KW_COUNT-1:0] alive_next;
	lckm_pkg::cmd_code_t           line_code;
	logic                          is_term;
	logic                          emit;
	logic                          room;

	assign pop = !q_status.empty && (!out_valid_q || out_ready);
	assign is_term = (head_item.kind == lckm_pkg::KIND_TERM);
	assign emit = pop && is_term && (stored_cnt_q != '0);
	assign room = (stored_cnt_q < lckm_pkg::CNT_W'(lckm_pkg::MAX_LINE - 1));

	// each keyword stays alive while the text so far is a prefix of it
	always_comb begin
		for (int k = 0; k < lckm_pkg::KW_COUNT; k++) begin
			alive_next[k] = alive_q[k] && (cmp_len_q < lckm_pkg::KW_LEN[k]) &&
				(lckm_pkg::KW_TEXT[k][cmp_len_q[lckm_pkg::KW_IDX_W-1:0]] == head_item.ch);
		end
	end

	// first keyword whose length matches wins
	always_comb begin
		line_code = lckm_pkg::CMD_UNKNOWN;
		for (int k = lckm_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (alive_q[k] && lckm_pkg::KW_LEN[k] == cmp_len_q) begin
				line_code = lckm_pkg::cmd_code_t'(3'(k));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_cnt_q <= '0;
			alive_q <= '1;
			text_ended_q <= 1'b0;
			cmp_len_q <= '0;
		end else if (pop) begin
			if (is_term) begin
				if (stored_cnt_q != '0) begin
					stored_cnt_q <= '0;
					alive_q <= '1;
					text_ended_q <= 1'b0;
					cmp_len_q <= '0;
				end
			end else if (room) begin
				stored_cnt_q <= stored_cnt_q + 1'b1;
				if (!text_ended_q) begin
					if (head_item.kind == lckm_pkg::KIND_ZERO) begin
						text_ended_q <= 1'b1;
					end else begin
						alive_q <= alive_next;
						if (cmp_len_q != lckm_pkg::LEN_SAT) begin
							cmp_len_q <= cmp_len_q + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_code_q <= line_code;
		end
	end

	assign out_valid = out_valid_q;
	assign out_code = out_code_q;

	property p_term_clears;
		@(posedge clk) disable iff (!arst_n)
		emit |=> (out_valid_q && stored_cnt_q == '0 && cmp_len_q == '0);
	endproperty
	a_term_clears: assert property (p_term_clears) else $error("line not cleared after result");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n)
		stored_cnt_q <= lckm_pkg::CNT_W'(lckm_pkg::MAX_LINE - 1);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("line count past limit");

	property p_ended_nonempty;
		@(posedge clk) disable iff (!arst_n)
		(text_ended_q || cmp_len_q != '0) |-> stored_cnt_q != '0;
	endproperty
	a_ended_nonempty: assert property (p_ended_nonempty) else $error("match state on empty line");

	property p_len_within_count;
		@(posedge clk) disable iff (!arst_n)
		cmp_len_q <= lckm_pkg::LEN_SAT;
	endproperty
	a_len_within_count: assert property (p_len_within_count) else $error("compared length overflow");

endmodule

[hw/rtl/line_command_keyword_matcher.sv]
// line command keyword matcher: one byte per cycle in unless stalled, one command code per non-empty line out
// path: a line-ending byte goes through the front register and the queue; the output register drives m_tvalid
// throughput: one byte per cycle while the queue is not full, set by the match-flag update in the back stage
// the four-entry queue between front and back holds bytes while the output stalls
// reset: arst_n clears the line state to empty with all keywords alive; no output pending
// depends on lckm_pkg, lckm_front, lckm_queue and lckm_back
module line_command_keyword_matcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata     // [2:0] command_code, [7:3] zero
);

	lckm_pkg::q_status_t q_status;
	lckm_pkg::item_t     push_item;
	lckm_pkg::item_t     head_item;
	lckm_pkg::cmd_code_t out_code;
	logic                push;
	logic                pop;

	lckm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	lckm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.status    (q_status)
	);

	lckm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head_item (head_item),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_code  (out_code)
	);

	assign m_tdata = {5'b0, out_code};

endmodule
